### rtl/core/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants of the i2c master bit engine
// command codes, phase encoding and the queued request record
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned MSB_INDEX = 7;
  localparam logic [3:0] BYTE_BITS = 4'd8;
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd10;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START_A = 4'd1,
    PH_START_B = 4'd2,
    PH_STOP    = 4'd3,
    PH_WR_LOW  = 4'd4,
    PH_WR_HIGH = 4'd5,
    PH_WR_TAIL = 4'd6,
    PH_RD_LOW  = 4'd7,
    PH_RD_HIGH = 4'd8,
    PH_RD_TAIL = 4'd9
  } phase_t;

  // classified request as held in the queue
  typedef struct packed {
    cmd_t       op;
    logic [7:0] data_byte;
    logic       nack_after_read;
    logic       sda_in;
  } req_t;

endpackage

### rtl/core/i2cm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_if: request and result channels of the i2c master bit engine
// valid/ready handshake with the payload fields alongside
// ----------------------------------------------------------------------------
interface i2cm_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] data_byte;
  logic       nack_after_read;
  logic       sda_in;

  modport source (output valid, command, data_byte, nack_after_read, sda_in,
                  input ready);
  modport sink (input valid, command, data_byte, nack_after_read, sda_in,
                output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_received;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res,
                  done_res, read_byte, ack_received, input ready);
  modport sink (input valid, scl_level, sda_level, sda_drive, busy_res,
                done_res, read_byte, ack_received, output ready);
endinterface

### rtl/core/i2cm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_front: request intake
// classifies the command code and holds requests in a two-entry queue
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic          clk,
  input  logic          rst,
  i2cm_req_if.sink      req,
  output logic          q_valid,
  input  logic          q_ready,
  output i2cm_pkg::req_t q_entry
);
  import i2cm_pkg::*;

  req_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  req_t       classified;

  // unknown codes behave as no command
  always_comb begin
    case (req.command)
      CMD_START, CMD_STOP, CMD_WRITE, CMD_READ: classified.op = cmd_t'(req.command);
      default:                                   classified.op = CMD_NONE;
    endcase
    classified.data_byte       = req.data_byte;
    classified.nack_after_read = req.nack_after_read;
    classified.sda_in          = req.sda_in;
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid & req.ready;
  assign q_valid   = (count != 2'd0);
  assign pop       = q_valid & q_ready;
  assign q_entry   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/i2cm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_back: bus sequencer
// steps the pin phases one tick per request and registers the result
// ----------------------------------------------------------------------------
module i2cm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wen,
  input  logic [15:0]    cfg_wdata,
  input  logic           q_valid,
  output logic           q_ready,
  input  i2cm_pkg::req_t q_entry,
  i2cm_res_if.source     res
);
  import i2cm_pkg::*;

  logic [15:0] phase_ticks;
  phase_t      phase,      phase_next;
  logic [3:0]  bit_count,  bit_count_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  shift_out,  shift_out_next;
  logic [7:0]  shift_in,   shift_in_next;
  logic        ack_flag,   ack_flag_next;
  logic        scl_reg,    scl_reg_next;
  logic        sda_reg,    sda_reg_next;
  logic        drive_reg,  drive_reg_next;
  logic        done_next;
  logic        step;
  logic [16:0] tick_sum;
  logic [15:0] limit;
  logic [3:0]  bit_inc;
  logic [7:0]  shift_shl;

  assign q_ready   = ~res.valid | res.ready;
  assign step      = q_valid & q_ready;
  assign tick_sum  = {1'b0, tick_count} + 17'd1;
  assign limit     = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
  assign bit_inc   = bit_count + 4'd1;
  assign shift_shl = {shift_out[6:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_wen) begin
      phase_ticks <= cfg_wdata;
    end
  end

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    tick_count_next = tick_count;
    shift_out_next  = shift_out;
    shift_in_next   = shift_in;
    ack_flag_next   = ack_flag;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    drive_reg_next  = drive_reg;
    done_next       = 1'b0;
    if (phase == PH_IDLE) begin
      tick_count_next = 16'd0;
      case (q_entry.op)
        CMD_START: begin
          sda_reg_next   = 1'b1;
          scl_reg_next   = 1'b1;
          drive_reg_next = 1'b1;
          phase_next     = PH_START_A;
        end
        CMD_STOP: begin
          sda_reg_next   = 1'b0;
          scl_reg_next   = 1'b1;
          drive_reg_next = 1'b1;
          phase_next     = PH_STOP;
        end
        CMD_WRITE: begin
          shift_out_next = q_entry.data_byte;
          bit_count_next = 4'd0;
          drive_reg_next = 1'b1;
          sda_reg_next   = q_entry.data_byte[MSB_INDEX];
          phase_next     = PH_WR_LOW;
        end
        CMD_READ: begin
          // bit 0 keeps the ack level for the end of the read
          shift_out_next = {7'd0, q_entry.nack_after_read};
          bit_count_next = 4'd0;
          drive_reg_next = 1'b0;
          phase_next     = PH_RD_LOW;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end else if (tick_sum < {1'b0, limit}) begin
      tick_count_next = tick_sum[15:0];
    end else begin
      tick_count_next = 16'd0;
      case (phase)
        PH_START_A: begin
          sda_reg_next = 1'b0;
          phase_next   = PH_START_B;
        end
        PH_START_B: begin
          scl_reg_next = 1'b0;
          phase_next   = PH_IDLE;
          done_next    = 1'b1;
        end
        PH_STOP: begin
          sda_reg_next = 1'b1;
          phase_next   = PH_IDLE;
          done_next    = 1'b1;
        end
        PH_WR_LOW: begin
          scl_reg_next = 1'b1;
          phase_next   = PH_WR_HIGH;
        end
        PH_RD_LOW: begin
          scl_reg_next = 1'b1;
          phase_next   = PH_RD_HIGH;
        end
        PH_WR_HIGH: begin
          if (bit_count >= BYTE_BITS) begin
            ack_flag_next = ~q_entry.sda_in;
          end
          scl_reg_next = 1'b0;
          phase_next   = PH_WR_TAIL;
        end
        PH_RD_HIGH: begin
          if (bit_count < BYTE_BITS) begin
            shift_in_next = {shift_in[6:0], q_entry.sda_in};
          end
          scl_reg_next = 1'b0;
          phase_next   = PH_RD_TAIL;
        end
        PH_WR_TAIL: begin
          if (bit_count >= BYTE_BITS) begin
            drive_reg_next = 1'b1;
            phase_next     = PH_IDLE;
            done_next      = 1'b1;
          end else begin
            bit_count_next = bit_inc;
            shift_out_next = shift_shl;
            if (bit_inc < BYTE_BITS) begin
              sda_reg_next = shift_shl[MSB_INDEX];
            end else begin
              drive_reg_next = 1'b0;
            end
            phase_next = PH_WR_LOW;
          end
        end
        PH_RD_TAIL: begin
          if (bit_count >= BYTE_BITS) begin
            phase_next = PH_IDLE;
            done_next  = 1'b1;
          end else begin
            bit_count_next = bit_inc;
            if (bit_inc >= BYTE_BITS) begin
              drive_reg_next = 1'b1;
              sda_reg_next   = shift_out[0];
            end
            phase_next = PH_RD_LOW;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= 4'd0;
      tick_count <= 16'd0;
      shift_out  <= 8'd0;
      shift_in   <= 8'd0;
      ack_flag   <= 1'b0;
      scl_reg    <= 1'b1;
      sda_reg    <= 1'b1;
      drive_reg  <= 1'b1;
    end else if (step) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      tick_count <= tick_count_next;
      shift_out  <= shift_out_next;
      shift_in   <= shift_in_next;
      ack_flag   <= ack_flag_next;
      scl_reg    <= scl_reg_next;
      sda_reg    <= sda_reg_next;
      drive_reg  <= drive_reg_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (q_ready) begin
      res.valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.scl_level    <= scl_reg_next;
      res.sda_level    <= sda_reg_next;
      res.sda_drive    <= drive_reg_next;
      res.busy_res     <= (phase_next != PH_IDLE);
      res.done_res     <= done_next;
      res.read_byte    <= shift_in_next;
      res.ack_received <= ack_flag_next;
    end
  end

endmodule

### rtl/core/i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine: i2c master bit engine
// one request per clock tick unless res stalls; drives scl/sda through start,
// stop, write byte and read byte sequences, phase length set by phase_ticks
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------------
//  req      | in  | valid / ready | command, data_byte, nack_after_read, sda_in
//  res      | out | valid / ready | scl_level, sda_level, sda_drive, busy_res,
//           |     |               | done_res, read_byte, ack_received
//  cfg      | in  | write enable  | cfg_wdata = phase_ticks
//
// one request per clock while res drains; each request gives exactly one result
// a request passes through the front queue and then the result register
// the back sequencer steps only when the result register is free or drained,
// so a stalled result backs up into the two-entry queue and then into req
// rst is synchronous and clears the queue, the pin state and phase_ticks to 10
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  i2cm_req_if.sink    req,
  i2cm_res_if.source  res
);
  import i2cm_pkg::*;

  // front to back queue head
  logic q_valid;
  logic q_ready;
  req_t q_entry;

  // intake: command decode and queue
  i2cm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry)
  );

  // sequencer: one tick per request, registered result
  i2cm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_entry   (q_entry),
    .res       (res)
  );

endmodule

### verif/i2cm_bus_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_bus_checker: scoreboard for the i2c master bit engine
// follows every accepted request with its own model of the engine, queues the
// expected pin and status word, and compares each accepted result against it
// ----------------------------------------------------------------------------
module i2cm_bus_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  i2cm_req_if         req,
  i2cm_res_if         res,
  output int          fail_count,
  output int          pending
);
  import i2cm_pkg::*;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drv;
    logic       busy;
    logic       done;
    logic [7:0] rbyte;
    logic       ack;
  } pin_word_t;

  // engine copy
  phase_t      eng_phase;
  logic [3:0]  bit_idx;
  logic [15:0] tick_cnt;
  logic [7:0]  out_shift;
  logic [7:0]  in_shift;
  logic        ack_seen;
  logic        scl_q;
  logic        sda_q;
  logic        drv_q;
  logic [15:0] ticks_cfg;

  pin_word_t   expected_pins[$];
  pin_word_t   want;
  pin_word_t   got;
  int          errors;

  task automatic clear_engine();
    eng_phase = PH_IDLE;
    bit_idx   = '0;
    tick_cnt  = '0;
    out_shift = '0;
    in_shift  = '0;
    ack_seen  = 1'b0;
    scl_q     = 1'b1;
    sda_q     = 1'b1;
    drv_q     = 1'b1;
    ticks_cfg = PHASE_TICKS_RESET;
  endtask

  function automatic pin_word_t advance_bus(input logic [2:0] c, input logic [7:0] d,
                                            input logic n, input logic s);
    pin_word_t w;
    int        lim;
    logic      fin;
    lim = (ticks_cfg == 16'd0) ? 1 : int'(ticks_cfg);
    fin = 1'b0;
    if (eng_phase == PH_IDLE) begin
      tick_cnt = '0;
      case (c)
        CMD_START: begin
          sda_q = 1'b1; scl_q = 1'b1; drv_q = 1'b1;
          eng_phase = PH_START_A;
        end
        CMD_STOP: begin
          sda_q = 1'b0; scl_q = 1'b1; drv_q = 1'b1;
          eng_phase = PH_STOP;
        end
        CMD_WRITE: begin
          out_shift = d;
          bit_idx   = '0;
          drv_q     = 1'b1;
          sda_q     = d[MSB_INDEX];
          eng_phase = PH_WR_LOW;
        end
        CMD_READ: begin
          out_shift = {7'd0, n};
          bit_idx   = '0;
          drv_q     = 1'b0;
          eng_phase = PH_RD_LOW;
        end
        default: ;
      endcase
    end else if (int'(tick_cnt) + 1 < lim) begin
      tick_cnt = tick_cnt + 16'd1;
    end else begin
      tick_cnt = '0;
      case (eng_phase)
        PH_START_A: begin
          sda_q = 1'b0;
          eng_phase = PH_START_B;
        end
        PH_START_B: begin
          scl_q = 1'b0;
          eng_phase = PH_IDLE;
          fin = 1'b1;
        end
        PH_STOP: begin
          sda_q = 1'b1;
          eng_phase = PH_IDLE;
          fin = 1'b1;
        end
        PH_WR_LOW: begin
          scl_q = 1'b1;
          eng_phase = PH_WR_HIGH;
        end
        PH_RD_LOW: begin
          scl_q = 1'b1;
          eng_phase = PH_RD_HIGH;
        end
        PH_WR_HIGH: begin
          if (bit_idx >= BYTE_BITS) ack_seen = ~s;
          scl_q = 1'b0;
          eng_phase = PH_WR_TAIL;
        end
        PH_RD_HIGH: begin
          if (bit_idx < BYTE_BITS) in_shift = {in_shift[6:0], s};
          scl_q = 1'b0;
          eng_phase = PH_RD_TAIL;
        end
        PH_WR_TAIL: begin
          if (bit_idx >= BYTE_BITS) begin
            drv_q = 1'b1;
            eng_phase = PH_IDLE;
            fin = 1'b1;
          end else begin
            bit_idx   = bit_idx + 4'd1;
            out_shift = out_shift << 1;
            if (bit_idx < BYTE_BITS) sda_q = out_shift[MSB_INDEX];
            else drv_q = 1'b0;
            eng_phase = PH_WR_LOW;
          end
        end
        PH_RD_TAIL: begin
          if (bit_idx >= BYTE_BITS) begin
            eng_phase = PH_IDLE;
            fin = 1'b1;
          end else begin
            bit_idx = bit_idx + 4'd1;
            if (bit_idx >= BYTE_BITS) begin
              drv_q = 1'b1;
              sda_q = out_shift[0];
            end
            eng_phase = PH_RD_LOW;
          end
        end
        default: eng_phase = PH_IDLE;
      endcase
    end
    w.scl   = scl_q;
    w.sda   = sda_q;
    w.drv   = drv_q;
    w.busy  = (eng_phase != PH_IDLE);
    w.done  = fin;
    w.rbyte = in_shift;
    w.ack   = ack_seen;
    return w;
  endfunction

  initial begin
    errors = 0;
    fail_count = 0;
    pending = 0;
    clear_engine();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_engine();
      expected_pins.delete();
    end else begin
      if (cfg_wen) ticks_cfg = cfg_wdata;
      // compare before queueing, latency keeps the two apart anyway
      if (res.valid && res.ready) begin
        got = '{res.scl_level, res.sda_level, res.sda_drive, res.busy_res,
                res.done_res, res.read_byte, res.ack_received};
        if (expected_pins.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] result with nothing expected: scl %b sda %b drv %b busy %b",
                     $time, got.scl, got.sda, got.drv, got.busy);
        end else begin
          want = expected_pins.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"[%0t] mismatch scl/sda/drv/busy/done/byte/ack",
                        " exp %b%b%b%b%b %h %b got %b%b%b%b%b %h %b"}, $time,
                       want.scl, want.sda, want.drv, want.busy, want.done,
                       want.rbyte, want.ack, got.scl, got.sda, got.drv,
                       got.busy, got.done, got.rbyte, got.ack);
          end
        end
      end
      if (req.valid && req.ready)
        expected_pins.push_back(advance_bus(req.command, req.data_byte,
                                            req.nack_after_read, req.sda_in));
    end
    pending    <= expected_pins.size();
    fail_count <= errors;
  end

endmodule

### verif/tb_i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_engine: testbench of the i2c master bit engine
// feeds tick requests carrying commands and sda samples, sweeps phase_ticks
// through its extremes, and lets the bus checker judge every result word
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_engine;
  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_QUOTA = 250;

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic [15:0] cfg_wdata;
  int          fails;
  int          pending;
  int          cycle_cnt;
  int          burst_left;
  int          sent;
  logic [15:0] cur_ticks;
  logic        long_hold_go;

  i2cm_req_if req_ch ();
  i2cm_res_if res_ch ();

  i2c_master_bit_engine dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  i2cm_bus_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .req        (req_ch),
    .res        (res_ch),
    .fail_count (fails),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // watchdog, generous against the slowest legal run
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ticks the engine spends on a command after the request that starts it
  function automatic int bus_ticks(input logic [2:0] c);
    int lim;
    lim = (cur_ticks == 16'd0) ? 1 : int'(cur_ticks);
    case (c)
      CMD_START: bus_ticks = 2 * lim;
      CMD_STOP:  bus_ticks = lim;
      CMD_WRITE: bus_ticks = 27 * lim;   // eight data bits and the ack bit
      CMD_READ:  bus_ticks = 27 * lim;
      default:   bus_ticks = 0;
    endcase
  endfunction

  // one request; the sender works in bursts with random gaps between them
  task automatic send_req(input logic [2:0] c, input logic [7:0] d,
                          input logic n, input logic s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    req_ch.valid           <= 1'b1;
    req_ch.command         <= c;
    req_ch.data_byte       <= d;
    req_ch.nack_after_read <= n;
    req_ch.sda_in          <= s;
    do @(posedge clk); while (!req_ch.ready);
    burst_left--;
    sent++;
  endtask

  // plain ticks; with noise set some of them carry commands the engine must ignore
  task automatic tick_on(input int count, input logic noisy);
    logic [2:0] c;
    repeat (count) begin
      c = (noisy && $urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : CMD_NONE;
      send_req(c, 8'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // a command and the ticks it needs to finish
  task automatic run_cmd(input logic [2:0] c, input logic [7:0] d, input logic n,
                         input logic noisy);
    send_req(c, d, n, 1'($urandom));
    tick_on(bus_ticks(c), noisy);
  endtask

  // stop offering, let every expected result drain, then write phase_ticks
  task automatic set_phase_ticks(input logic [15:0] v);
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    cur_ticks  = v;
    burst_left = 0;
  endtask

  // receiver: one long hold-off on request, otherwise a changing stall pattern
  initial begin : sink_side
    int   mode;
    int   mode_left;
    int   hold_left;
    logic hold_used;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    hold_used = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (long_hold_go && !hold_used) begin
        // long hold-off, fills the engine until it stalls its request side
        hold_used = 1'b1;
        hold_left = LONG_HOLD;
        res_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0:       res_ch.ready <= 1'b1;
          1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= (mode_left % 3 != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [15:0] sweep [0:4];
    int          r;
    int          n;
    int          phase_start;
    logic [2:0]  c;
    burst_left   = 0;
    sent         = 0;
    cur_ticks    = PHASE_TICKS_RESET;
    long_hold_go <= 1'b0;
    rst          <= 1'b1;
    cfg_wen      <= 1'b0;
    cfg_wdata    <= 16'd0;
    req_ch.valid           <= 1'b0;
    req_ch.command         <= CMD_NONE;
    req_ch.data_byte       <= 8'd0;
    req_ch.nack_after_read <= 1'b0;
    req_ch.sda_in          <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset timing, write straight out of reset with scl still high
    run_cmd(CMD_WRITE, 8'hA5, 1'b0, 1'b0);

    // shortest phase, every command and both byte extremes
    set_phase_ticks(16'd1);
    run_cmd(CMD_START, 8'h00, 1'b0, 1'b0);
    run_cmd(CMD_WRITE, 8'hFF, 1'b0, 1'b0);
    run_cmd(CMD_WRITE, 8'h00, 1'b1, 1'b0);
    run_cmd(CMD_READ,  8'hFF, 1'b0, 1'b0);
    run_cmd(CMD_READ,  8'h00, 1'b1, 1'b0);
    // commands arriving while busy are dropped
    run_cmd(CMD_WRITE, 8'h5A, 1'b1, 1'b1);
    run_cmd(CMD_STOP,  8'h00, 1'b0, 1'b0);
    // undefined command codes behave as none
    send_req(3'd5, 8'hFF, 1'b1, 1'b1);
    send_req(3'd6, 8'h00, 1'b0, 1'b0);
    send_req(3'd7, 8'h81, 1'b1, 1'b0);
    send_req(CMD_NONE, 8'h7E, 1'b0, 1'b1);
    // read right after stop, scl still high
    run_cmd(CMD_READ, 8'h00, 1'b0, 1'b0);

    // zero phase length runs as one tick per phase
    set_phase_ticks(16'd0);
    run_cmd(CMD_START, 8'h00, 1'b0, 1'b0);
    run_cmd(CMD_WRITE, 8'h3C, 1'b0, 1'b0);
    run_cmd(CMD_STOP,  8'h00, 1'b0, 1'b0);

    // longest phase: a stop left part way, the next setting lets it finish
    set_phase_ticks(16'hFFFF);
    send_req(CMD_STOP, 8'h00, 1'b0, 1'b0);
    tick_on(20, 1'b1);

    // random part: mostly whole commands, some cut short or padded with noise
    sweep[0] = 16'd1;
    sweep[1] = 16'd2;
    sweep[2] = 16'd3;
    sweep[3] = 16'd0;
    sweep[4] = 16'($urandom_range(1, 5));
    long_hold_go <= 1'b1;
    for (int p = 0; p < 5; p++) begin
      set_phase_ticks(sweep[p]);
      phase_start = sent;
      while (sent - phase_start < PHASE_QUOTA) begin
        r = $urandom_range(0, 99);
        if (r < 30)      c = CMD_WRITE;
        else if (r < 55) c = CMD_READ;
        else if (r < 72) c = CMD_START;
        else if (r < 90) c = CMD_STOP;
        else begin
          r = $urandom_range(0, 3);
          c = (r == 0) ? CMD_NONE : 3'(4 + r);
        end
        n = bus_ticks(c);
        // a broken sequence lets the next command land while still busy
        if (n > 0 && $urandom_range(0, 9) == 0) n = $urandom_range(0, n - 1);
        send_req(c, 8'($urandom), 1'($urandom), 1'($urandom));
        tick_on(n, $urandom_range(0, 3) == 0);
        tick_on($urandom_range(0, 2), 1'b0);
      end
    end

    // drain and settle
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_if.sv
rtl/core/i2cm_front.sv
rtl/core/i2cm_back.sv
rtl/core/i2c_master_bit_engine.sv
verif/i2cm_bus_checker.sv
verif/tb_i2c_master_bit_engine.sv
